// ----- design/cdq_pkg.sv -----
// cdq_pkg: shared codes and types of the circular deque
// operation codes, status codes, field widths, configuration reset value
// no dependencies
package cdq_pkg;

    localparam int CFG_WIDTH = 8;
    localparam int OP_WIDTH  = 2;
    localparam int ST_WIDTH  = 2;
    localparam int OUT_WIDTH = 32;

    localparam logic [OP_WIDTH-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [ST_WIDTH-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_WIDTH-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_WIDTH-1:0] CAP_RESET = 8'd128;

    typedef struct packed {
        logic [ST_WIDTH-1:0] status;
        logic                now_empty;
        logic                now_full;
    } t_flags;

endpackage

// ----- design/cdq_cell.sv -----
// cdq_cell: one storage cell of the rotating ring
// takes its neighbor's word every cycle, or a new word when loaded
// no dependencies
module cdq_cell #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [WIDTH-1:0] i_load_data,
    input  logic [WIDTH-1:0] i_shift_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    assign n_data = i_load ? i_load_data : i_shift_data;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- design/cdq_ring.sv -----
// cdq_ring: ring of cdq_cell instances that rotates one place every cycle
// a phase counter tracks which entry sits in the head cell
// depends on cdq_cell
module cdq_ring #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int IW    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [IW-1:0]    o_phase,
    output logic [WIDTH-1:0] o_head
);

    logic [WIDTH-1:0] w_cell [DEPTH];
    logic [IW-1:0]    r_phase;
    logic [IW-1:0]    n_phase;

    // entry leaving the head cell wraps to the tail cell, where a write may replace it
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cdq_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_load       (i_wr_en && (g == DEPTH - 1)),
            .i_load_data  (i_wr_data),
            .i_shift_data (w_cell[(g + 1) % DEPTH]),
            .o_data       (w_cell[g])
        );
    end

    assign n_phase = (r_phase == IW'(DEPTH - 1)) ? '0 : r_phase + IW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;
    assign o_head  = w_cell[0];

endmodule

// ----- design/circular_deque.sv -----
// circular_deque: double-ended queue over a rotating ring of cells
// refused items finish at acceptance without touching the ring; pushes and pops wait
// for their entry to reach the head cell of the ring; one item in flight at a time
// a new item is taken only once the last is through, so ring rotation and output stalls set the pace
// reset: indices zero, deque empty, capacity 128; ring contents are not cleared
module circular_deque #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration: capacity in use
    input  logic                                 i_cfg_we,
    input  logic [cdq_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [cdq_pkg::OP_WIDTH-1:0]         i_op,
    input  logic signed [cdq_pkg::OUT_WIDTH-1:0] i_push_value,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cdq_pkg::OUT_WIDTH-1:0] o_popped_value,
    output logic [cdq_pkg::ST_WIDTH-1:0]         o_status,
    output logic                                 o_now_empty,
    output logic                                 o_now_full
);

    localparam int IW = $clog2(DEPTH);
    // capacity arithmetic must hold both DEPTH and any register value
    localparam int CW = (IW + 1 > cdq_pkg::CFG_WIDTH) ? IW + 1 : cdq_pkg::CFG_WIDTH;
    localparam int OW = cdq_pkg::OUT_WIDTH;

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;   // ready for an item
    localparam logic [1:0] S_SEEK = 2'd1;   // waiting for the entry to rotate to the head
    localparam logic [1:0] S_HOLD = 2'd2;   // result done, output register still busy

    // index step forward, wrapping at the capacity
    function automatic logic [IW-1:0] f_adv(input logic [IW-1:0] idx,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(idx) + CW'(1);
        f_adv = (nxt >= cap) ? '0 : nxt[IW-1:0];
    endfunction

    // index step back; an index beyond the capacity also lands on the last slot
    function automatic logic [IW-1:0] f_ret(input logic [IW-1:0] idx,
                                            input logic [CW-1:0] cap);
        logic [CW-1:0] ext;
        logic [CW-1:0] lim;
        ext = CW'(idx);
        lim = cap - CW'(1);
        if (ext == '0 || ext > cap) begin
            f_ret = lim[IW-1:0];
        end else begin
            f_ret = idx - IW'(1);
        end
    endfunction

    // state registers
    logic [cdq_pkg::CFG_WIDTH-1:0] r_cap;
    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [IW-1:0]                 r_front;
    logic [IW-1:0]                 r_rear;
    logic                          r_empty;
    logic                          r_out_valid;
    logic                          n_out_valid;

    // pending item
    logic [IW-1:0]                 r_slot;
    logic                          r_res_wr;
    logic [DATA_WIDTH-1:0]         r_res_data;
    logic [DATA_WIDTH-1:0]         r_res_word;
    cdq_pkg::t_flags               r_res_flags;

    // output register
    logic [OW-1:0]                 r_out_value;
    cdq_pkg::t_flags               r_out_flags;

    // decode of the offered item against the current indices
    logic [CW-1:0]                 w_cap;
    logic                          w_is_push;
    logic                          w_is_front;
    logic                          w_full_now;
    logic [IW-1:0]                 c_front;
    logic [IW-1:0]                 c_rear;
    logic                          c_empty;
    logic [IW-1:0]                 c_slot;
    logic                          c_access;
    cdq_pkg::t_flags               c_flags;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_hit;
    logic                          w_load_out;
    logic [IW-1:0]                 w_phase;
    logic [DATA_WIDTH-1:0]         w_head;
    logic [DATA_WIDTH-1:0]         w_push_word;
    logic [DATA_WIDTH-1:0]         w_cur_word;
    logic [OW-1:0]                 w_cur_out;
    cdq_pkg::t_flags               w_cur_flags;

    // effective capacity: zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        w_cap = CW'(r_cap);
        if (w_cap == '0) begin
            w_cap = CW'(1);
        end else if (w_cap > CW'(DEPTH)) begin
            w_cap = CW'(DEPTH);
        end
    end

    // width adaption of the pushed value and of the word handed out
    if (DATA_WIDTH <= OW) begin : g_push_narrow
        assign w_push_word = i_push_value[DATA_WIDTH-1:0];
    end else begin : g_push_wide
        assign w_push_word = {{(DATA_WIDTH - OW){i_push_value[OW-1]}}, i_push_value};
    end

    if (DATA_WIDTH >= OW) begin : g_out_wide
        assign w_cur_out = w_cur_word[OW-1:0];
    end else begin : g_out_narrow
        assign w_cur_out = {{(OW - DATA_WIDTH){w_cur_word[DATA_WIDTH-1]}}, w_cur_word};
    end

    // operation decode
    always_comb begin
        case (i_op)
            cdq_pkg::OP_PUSH_REAR: begin
                w_is_push  = 1'b1;
                w_is_front = 1'b0;
            end
            cdq_pkg::OP_PUSH_FRONT: begin
                w_is_push  = 1'b1;
                w_is_front = 1'b1;
            end
            cdq_pkg::OP_POP_FRONT: begin
                w_is_push  = 1'b0;
                w_is_front = 1'b1;
            end
            default: begin
                w_is_push  = 1'b0;
                w_is_front = 1'b0;
            end
        endcase
    end

    assign w_full_now = !r_empty && (f_adv(r_rear, w_cap) == r_front);

    // index update, status and slot of the offered item
    always_comb begin
        c_front        = r_front;
        c_rear         = r_rear;
        c_empty        = r_empty;
        c_slot         = '0;
        c_access       = 1'b0;
        c_flags.status = cdq_pkg::ST_DONE;
        if (w_is_push) begin
            if (w_full_now) begin
                c_flags.status = cdq_pkg::ST_FULL;
            end else if (r_empty) begin
                // first entry always goes to slot zero
                c_front  = '0;
                c_rear   = '0;
                c_empty  = 1'b0;
                c_slot   = '0;
                c_access = 1'b1;
            end else if (!w_is_front) begin
                c_rear   = f_adv(r_rear, w_cap);
                c_slot   = c_rear;
                c_access = 1'b1;
            end else begin
                c_front  = f_ret(r_front, w_cap);
                c_slot   = c_front;
                c_access = 1'b1;
            end
        end else begin
            if (r_empty) begin
                c_flags.status = cdq_pkg::ST_EMPTY;
            end else begin
                c_slot   = w_is_front ? r_front : r_rear;
                c_access = 1'b1;
                if (r_front == r_rear) begin
                    // last entry leaves: indices go home
                    c_front = '0;
                    c_rear  = '0;
                    c_empty = 1'b1;
                end else if (w_is_front) begin
                    c_front = f_adv(r_front, w_cap);
                end else begin
                    c_rear = f_ret(r_rear, w_cap);
                end
            end
        end
        c_flags.now_empty = c_empty;
        c_flags.now_full  = !c_empty && (f_adv(c_rear, w_cap) == c_front);
    end

    // ring of cells
    cdq_ring #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH),
        .IW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_hit && r_res_wr),
        .i_wr_data (r_res_data),
        .o_phase   (w_phase),
        .o_head    (w_head)
    );

    // handshake and result steering
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_hit      = (r_state == S_SEEK) && (w_phase == r_slot);

    // result loads into a free output register at acceptance when nothing is touched, on a ring hit, or from hold
    assign w_load_out = w_out_free &&
                        ((w_accept && !c_access) || w_hit || (r_state == S_HOLD));

    assign w_cur_flags = (r_state == S_IDLE) ? c_flags : r_res_flags;
    always_comb begin
        if (r_state == S_IDLE) begin
            w_cur_word = '0;
        end else if (r_state == S_SEEK && !r_res_wr) begin
            w_cur_word = w_head;
        end else begin
            w_cur_word = r_res_word;
        end
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (c_access) begin
                        n_state = S_SEEK;
                    end else if (!w_out_free) begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_SEEK: begin
                if (w_hit) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= cdq_pkg::CAP_RESET;
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_front <= c_front;
                r_rear  <= c_rear;
                r_empty <= c_empty;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot      <= c_slot;
            r_res_wr    <= w_is_push;
            r_res_data  <= w_push_word;
            r_res_word  <= '0;
            r_res_flags <= c_flags;
        end else if (w_hit && !r_res_wr) begin
            // keep the popped word in case the output is still busy
            r_res_word <= w_head;
        end
        if (w_load_out) begin
            r_out_value <= w_cur_out;
            r_out_flags <= w_cur_flags;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_flags.status;
    assign o_now_empty    = r_out_flags.now_empty;
    assign o_now_full     = r_out_flags.now_full;

endmodule
